FILE: rtl/core/ibt_pkg.sv
// Package for the input binding table: sizes, opcodes, status codes, flag bits.
// Used by input_binding_table_core, ibt_checker and testbench. No dependencies.
`timescale 1ns / 1ps
package ibt_pkg;
  localparam int TABLE_SLOTS_DEF = 16;
  localparam int AXIS_SLOTS_DEF  = 16;
  localparam int EVENT_DEPTH_DEF = 16;

  localparam logic [1:0] OP_MAP  = 2'd0;
  localparam logic [1:0] OP_EVT  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_GET  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_SAME     = 3'd2;
  localparam logic [2:0] ST_TFULL    = 3'd3;
  localparam logic [2:0] ST_AFULL    = 3'd4;
  localparam logic [2:0] ST_QFULL    = 3'd5;

  localparam int F_DOWN = 0;
  localparam int F_HELD = 1;
  localparam int F_UP   = 2;
endpackage

FILE: rtl/core/ibt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ibt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/input_binding_table_core.sv
// Input binding table top level: two linear-probe hash tables, axis records, event queue.
// Depends on ibt_pkg and ibt_ram.
//
// Usage: items arrive on s_axis (opcode in tuser, other fields in tdata).
// Every item gives exactly one result beat on m_axis (status in tuser).
// Opcodes: map code to binding, queue event, frame tick, get axis.
// One item is handled at a time; s_axis_tready is high only when idle.
// A probe reads one table slot at a time (registered RAM read, S_PRD then
// S_PCHK) and walks up to TABLE_SLOTS slots. Map: two probes, code table
// then bind table. Event: queued without a probe. Get: one probe plus an
// axis read. Tick: edge clearing over all AXIS_SLOTS axes, then per queued
// event one probe and a read-modify-write of the axis. All probing goes
// through one slot walker and one key comparator.
// Reset clears valid bits, counters, the touched mask and axis flags; axis
// records read as zero until written (per-axis valid bits).
// If m_axis_tready is low the result is held in the output register and the
// next item is not taken until the result beat is accepted.
`timescale 1ns / 1ps
module input_binding_table_core #(
  parameter int TABLE_SLOTS = ibt_pkg::TABLE_SLOTS_DEF,
  parameter int AXIS_SLOTS  = ibt_pkg::AXIS_SLOTS_DEF,
  parameter int EVENT_DEPTH = ibt_pkg::EVENT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_type[15:0], code_value[31:16], bind_value[47:32], press_flag[48],
  // release_flag[49], stamp[81:50], payload[113:82], zero pad to 120
  input  logic [119:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // down_edge[0], held[1], up_edge[2], pressed_stamp[34:3],
  // released_stamp[66:35], axis_payload[98:67], axis_kind[114:99], pad to 120
  output logic [119:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser
);
  localparam int TW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int AW = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;
  localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int TCW = $clog2(TABLE_SLOTS + 1);
  localparam int ACW = $clog2(AXIS_SLOTS + 1);
  localparam int ECW = $clog2(EVENT_DEPTH + 1);
  localparam int TRAM = 1 << TW;
  localparam int ARAM = 1 << AW;
  localparam int ERAM = 1 << EW;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_PRD   = 14'h0002,  // probe: issue read
    S_PCHK  = 14'h0004,  // probe: check slot
    S_MAPC  = 14'h0008,  // map: code probe done, start bind probe
    S_MAPB  = 14'h0010,  // map: decide
    S_MAPW  = 14'h0020,  // map: write bind entry / link
    S_GETR  = 14'h0040,
    S_GETD  = 14'h0080,
    S_CLR   = 14'h0100,  // tick: clear edges
    S_ERD   = 14'h0200,  // tick: read event
    S_ELK   = 14'h0400,  // tick: event read, start probe
    S_EAX   = 14'h0800,  // tick: read axis
    S_EUPD  = 14'h1000,  // tick: update axis
    S_OUT   = 14'h2000
  } state_t;

  state_t state;
  logic [1:0]  op;
  logic [15:0] ktype;
  logic [31:0] ckey, bkey, pkey;
  logic        pflag, rflag;
  logic [31:0] istamp, ipay;

  // probe walker
  logic          ptab;      // 0 code table, 1 bind table
  logic          pfind;     // find mode (match used only) vs place mode
  logic [TW-1:0] pidx;
  logic [TCW-1:0] pcnt;
  logic          phit, pfree;
  logic [TW-1:0] pslot;
  state_t        pret;
  logic          c_hit, c_ok;
  logic [TW-1:0] c_slot;

  logic [TABLE_SLOTS-1:0] code_used, bind_used;
  logic [ACW-1:0]         axes_allocated;
  logic [AXIS_SLOTS-1:0]  touched, axis_valid;
  logic [2:0]             axis_flags [AXIS_SLOTS];
  logic [ECW-1:0]         event_count, eidx;
  logic [AW-1:0]          ax, cidx;
  logic [2:0]             status;

  // RAMs
  logic          ck_we, bk_we, cl_we, bl_we;
  logic [TW-1:0] t_waddr;
  logic [31:0]   t_wkey;
  logic [AW-1:0] t_wlink;
  logic [31:0]   ck_rd, bk_rd;
  logic [AW-1:0] cl_rd, bl_rd;
  logic [TW-1:0] t_raddr;

  logic          a_we;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [111:0]  a_wdata, a_rd;   // type, data, released, pressed
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [97:0]   e_wdata, e_rd;   // up, down, key, payload, stamp

  ibt_ram #(.WIDTH(32), .DEPTH(TRAM)) u_ckey (.clk, .we(ck_we), .waddr(t_waddr),
    .wdata(t_wkey), .raddr(t_raddr), .rdata(ck_rd));
  ibt_ram #(.WIDTH(32), .DEPTH(TRAM)) u_bkey (.clk, .we(bk_we), .waddr(t_waddr),
    .wdata(t_wkey), .raddr(t_raddr), .rdata(bk_rd));
  ibt_ram #(.WIDTH(AW), .DEPTH(TRAM)) u_clink (.clk, .we(cl_we), .waddr(t_waddr),
    .wdata(t_wlink), .raddr(t_raddr), .rdata(cl_rd));
  ibt_ram #(.WIDTH(AW), .DEPTH(TRAM)) u_blink (.clk, .we(bl_we), .waddr(t_waddr),
    .wdata(t_wlink), .raddr(t_raddr), .rdata(bl_rd));
  ibt_ram #(.WIDTH(112), .DEPTH(ARAM)) u_axis (.clk, .we(a_we), .waddr(a_waddr),
    .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rd));
  ibt_ram #(.WIDTH(98), .DEPTH(ERAM)) u_evq (.clk, .we(e_we), .waddr(e_waddr),
    .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rd));

  logic [AW-1:0] cur_ax;      // axis chosen by map
  logic [TW-1:0] bslot_r;
  logic [111:0]  arec;
  logic [2:0]    aflg;

  // combinational probe check of current slot
  logic        s_used, s_match;
  logic [31:0] s_key;
  always_comb begin
    s_used  = ptab ? bind_used[pidx] : code_used[pidx];
    s_key   = ptab ? bk_rd : ck_rd;
    s_match = s_used && (s_key == pkey);
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign e_wdata = {rflag, pflag, bkey, ipay, istamp};
  assign t_raddr = pidx;
  assign a_raddr = ax;
  assign arec    = axis_valid[ax] ? a_rd : '0;

  always_ff @(posedge clk) begin
    ck_we <= 1'b0; bk_we <= 1'b0; cl_we <= 1'b0; bl_we <= 1'b0;
    a_we  <= 1'b0; e_we  <= 1'b0;
    if (rst) begin
      state          <= S_IDLE;
      code_used      <= '0;
      bind_used      <= '0;
      axes_allocated <= '0;
      touched        <= '0;
      axis_valid     <= '0;
      event_count    <= '0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < AXIS_SLOTS; i++) axis_flags[i] <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op     <= s_axis_tuser;
            ktype  <= s_axis_tdata[15:0];
            ckey   <= {s_axis_tdata[15:0], s_axis_tdata[31:16]};
            bkey   <= {s_axis_tdata[15:0], s_axis_tdata[47:32]};
            pflag  <= s_axis_tdata[48];
            rflag  <= s_axis_tdata[49];
            istamp <= s_axis_tdata[81:50];
            ipay   <= s_axis_tdata[113:82];
            status <= ibt_pkg::ST_OK;
            case (s_axis_tuser)
              ibt_pkg::OP_MAP, ibt_pkg::OP_GET: begin
                ptab  <= 1'b0;
                pfind <= (s_axis_tuser == ibt_pkg::OP_GET);
                pkey  <= {s_axis_tdata[15:0], s_axis_tdata[31:16]};
                pidx  <= TW'({s_axis_tdata[15:0], s_axis_tdata[31:16]} % TABLE_SLOTS);
                pcnt  <= '0;
                pret  <= (s_axis_tuser == ibt_pkg::OP_GET) ? S_GETR : S_MAPC;
                state <= S_PRD;
              end
              ibt_pkg::OP_EVT: begin
                state <= S_OUT;
              end
              default: begin
                cidx  <= '0;
                state <= S_CLR;
              end
            endcase
          end
        end
        S_PRD: state <= S_PCHK;   // slot read in flight
        S_PCHK: begin
          if (pfind ? s_match : (!s_used || s_match)) begin
            phit  <= s_match;
            pfree <= 1'b1;
            pslot <= pidx;
            state <= pret;
          end else if (pcnt == TCW'(TABLE_SLOTS - 1)) begin
            phit  <= 1'b0;
            pfree <= 1'b0;
            state <= pret;
          end else begin
            pcnt  <= pcnt + 1'b1;
            pidx  <= (pidx == TW'(TABLE_SLOTS - 1)) ? '0 : pidx + 1'b1;
            state <= S_PRD;
          end
        end
        S_MAPC: begin
          // read data still holds the code slot the probe stopped at
          cur_ax <= cl_rd;
          c_hit  <= phit;
          c_ok   <= pfree;
          c_slot <= pslot;
          ptab   <= 1'b1;
          pkey   <= bkey;
          pidx   <= TW'(bkey % TABLE_SLOTS);
          pcnt   <= '0;
          pret   <= S_MAPB;
          state  <= S_PRD;
        end
        S_MAPB: begin
          bslot_r <= pslot;
          if (!c_ok || !pfree) begin
            status <= ibt_pkg::ST_TFULL;
            state  <= S_OUT;
          end else if (!c_hit) begin
            if (axes_allocated >= ACW'(AXIS_SLOTS)) begin
              status <= ibt_pkg::ST_AFULL;
              state  <= S_OUT;
            end else begin
              cur_ax         <= axes_allocated[AW-1:0];
              axes_allocated <= axes_allocated + 1'b1;
              code_used[c_slot] <= 1'b1;
              ck_we   <= 1'b1; cl_we <= 1'b1;
              t_waddr <= c_slot; t_wkey <= ckey; t_wlink <= axes_allocated[AW-1:0];
              state   <= S_MAPW;
            end
          end else if (phit && (bl_rd == cur_ax)) begin
            // bl_rd holds the link of the bind slot the probe stopped at
            status <= ibt_pkg::ST_SAME;
            state  <= S_OUT;
          end else begin
            state <= S_MAPW;
          end
        end
        S_MAPW: begin
          bind_used[bslot_r] <= 1'b1;
          bk_we   <= 1'b1; bl_we <= 1'b1;
          t_waddr <= bslot_r; t_wkey <= bkey; t_wlink <= cur_ax;
          ax      <= cur_ax;
          pfree   <= 1'b0;   // wait for the axis read
          pret    <= S_EUPD;
          state   <= S_EUPD;
        end
        S_GETR: begin
          if (!phit) begin
            status <= ibt_pkg::ST_NOTFOUND;
            state  <= S_OUT;
          end else begin
            state <= S_GETD;
          end
        end
        S_GETD: begin
          ax    <= cl_rd;
          state <= S_EAX;
          pret  <= S_OUT;
        end
        S_CLR: begin
          if (touched[cidx]) begin
            axis_flags[cidx][ibt_pkg::F_DOWN] <= 1'b0;
            axis_flags[cidx][ibt_pkg::F_UP]   <= 1'b0;
          end
          touched[cidx] <= 1'b0;
          if (cidx == AW'(AXIS_SLOTS - 1)) begin
            eidx  <= '0;
            state <= S_ERD;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_ERD: begin
          if (eidx >= event_count) begin
            event_count <= '0;
            state       <= S_OUT;
          end else begin
            e_raddr <= eidx[EW-1:0];
            state   <= S_ELK;
            pcnt    <= '1;   // marks event not yet latched
          end
        end
        S_ELK: begin
          if (pcnt == '1) begin
            pcnt <= '0;      // wait for registered read
          end else begin
            ptab  <= 1'b1;
            pfind <= 1'b1;
            pkey  <= e_rd[95:64];
            pidx  <= TW'(e_rd[95:64] % TABLE_SLOTS);
            pcnt  <= '0;
            pret  <= S_EAX;
            state <= S_PRD;
          end
        end
        S_EAX: begin
          if (op == ibt_pkg::OP_TICK && !phit) begin
            eidx  <= eidx + 1'b1;
            state <= S_ERD;
          end else begin
            if (op == ibt_pkg::OP_TICK) ax <= bl_rd;
            pfree <= 1'b0;   // read latency marker
            state <= S_EUPD;
            pret  <= S_EUPD;
          end
        end
        S_EUPD: begin
          if (!pfree && pret == S_EUPD) begin
            pfree <= 1'b1;   // a_rd valid next cycle
          end else if (op == ibt_pkg::OP_GET) begin
            aflg   <= axis_flags[ax];
            state  <= S_OUT;
          end else begin
            a_we    <= 1'b1;
            a_waddr <= ax;
            axis_valid[ax] <= 1'b1;
            if (op == ibt_pkg::OP_MAP) begin
              a_wdata <= {ktype, arec[95:0]};
              state   <= S_OUT;
            end else begin
              if (e_rd[96] && !axis_flags[ax][ibt_pkg::F_HELD]) begin
                axis_flags[ax] <= axis_flags[ax] | 3'b011;
                a_wdata <= {arec[111:96], e_rd[63:32], arec[63:32], e_rd[31:0]};
              end else if (e_rd[97]) begin
                axis_flags[ax] <= (axis_flags[ax] | 3'b100) & 3'b101;
                a_wdata <= {arec[111:96], e_rd[63:32], e_rd[31:0], arec[31:0]};
              end else begin
                a_wdata <= {arec[111:96], e_rd[63:32], arec[63:0]};
              end
              touched[ax] <= 1'b1;
              eidx  <= eidx + 1'b1;
              state <= S_ERD;
            end
          end
        end
        S_OUT: begin
          if (op == ibt_pkg::OP_EVT) begin
            if (event_count >= ECW'(EVENT_DEPTH)) begin
              status <= ibt_pkg::ST_QFULL;
            end else begin
              e_we        <= 1'b1;
              e_waddr     <= event_count[EW-1:0];
              event_count <= event_count + 1'b1;
            end
          end
          state <= S_IDLE;
          m_axis_tvalid <= 1'b1;
          m_axis_tuser  <= (op == ibt_pkg::OP_EVT && event_count >= ECW'(EVENT_DEPTH))
                           ? ibt_pkg::ST_QFULL : status;
          if (op == ibt_pkg::OP_GET && status == ibt_pkg::ST_OK) begin
            m_axis_tdata <= {5'd0, arec[111:96], arec[95:64], arec[63:32], arec[31:0],
                             aflg[ibt_pkg::F_UP], aflg[ibt_pkg::F_HELD],
                             aflg[ibt_pkg::F_DOWN]};
          end else begin
            m_axis_tdata <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/ibt_checker.sv
// Checker for input_binding_table_core: watches both stream channels, models the
// binding tables, axes and event queue, and compares every result beat. Uses ibt_pkg.
`timescale 1ns / 1ps
module ibt_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending_count
);
  localparam int NSLOT = ibt_pkg::TABLE_SLOTS_DEF;
  localparam int NAXIS = ibt_pkg::AXIS_SLOTS_DEF;
  localparam int NEVT  = ibt_pkg::EVENT_DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] kind;
    logic [31:0] payload;
    logic [31:0] rel_stamp;
    logic [31:0] prs_stamp;
    logic        up, held, down;
  } axis_view_t;

  logic [31:0] ckey_tab [NSLOT];
  logic        cused    [NSLOT];
  logic [3:0]  clink    [NSLOT];
  logic [31:0] bkey_tab [NSLOT];
  logic        bused    [NSLOT];
  logic [3:0]  blink    [NSLOT];
  int          n_axes;
  logic [2:0]  aflags   [NAXIS];
  logic [15:0] akind    [NAXIS];
  logic [31:0] aprs     [NAXIS];
  logic [31:0] arel     [NAXIS];
  logic [31:0] adata    [NAXIS];
  logic        touched  [NAXIS];
  logic [33:0] ev_key   [NEVT];
  logic [63:0] ev_word  [NEVT];
  int          ev_count;
  axis_view_t  expected_views [$];

  // Returns slot holding key or first free slot; -1 when full. hit set on key match.
  function automatic int place_slot(bit is_code, logic [31:0] key, output bit hit);
    int i;
    i = int'(key % NSLOT);
    hit = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (!(is_code ? cused[i] : bused[i])) return i;
      if ((is_code ? ckey_tab[i] : bkey_tab[i]) == key) begin
        hit = 1;
        return i;
      end
      i = (i + 1) % NSLOT;
    end
    return -1;
  endfunction

  function automatic int find_slot(bit is_code, logic [31:0] key);
    int i;
    i = int'(key % NSLOT);
    for (int n = 0; n < NSLOT; n++) begin
      if (is_code ? (cused[i] && ckey_tab[i] == key) : (bused[i] && bkey_tab[i] == key))
        return i;
      i = (i + 1) % NSLOT;
    end
    return -1;
  endfunction

  function automatic logic [2:0] apply_map(logic [31:0] ck, logic [31:0] bk, logic [15:0] ty);
    bit ch, bh;
    int cs, bs, ax;
    cs = place_slot(1'b1, ck, ch);
    bs = place_slot(1'b0, bk, bh);
    if (cs < 0 || bs < 0) return ibt_pkg::ST_TFULL;
    if (!ch) begin
      if (n_axes >= NAXIS) return ibt_pkg::ST_AFULL;
      ax = n_axes;
      n_axes++;
      ckey_tab[cs] = ck;
      cused[cs] = 1'b1;
      clink[cs] = 4'(ax);
    end else begin
      ax = int'(clink[cs]);
      if (bh && blink[bs] == 4'(ax)) return ibt_pkg::ST_SAME;
    end
    bkey_tab[bs] = bk;
    bused[bs] = 1'b1;
    blink[bs] = 4'(ax);
    akind[ax] = ty;
    return ibt_pkg::ST_OK;
  endfunction

  function automatic void apply_tick();
    int s, ax;
    for (int i = 0; i < NAXIS; i++) begin
      if (touched[i]) begin
        aflags[i][ibt_pkg::F_DOWN] = 1'b0;
        aflags[i][ibt_pkg::F_UP] = 1'b0;
      end
      touched[i] = 1'b0;
    end
    for (int i = 0; i < ev_count; i++) begin
      s = find_slot(1'b0, ev_key[i][31:0]);
      if (s < 0) continue;
      ax = int'(blink[s]);
      if (ev_key[i][32] && !aflags[ax][ibt_pkg::F_HELD]) begin
        aflags[ax][ibt_pkg::F_DOWN] = 1'b1;
        aflags[ax][ibt_pkg::F_HELD] = 1'b1;
        aprs[ax] = ev_word[i][31:0];
      end else if (ev_key[i][33]) begin
        aflags[ax][ibt_pkg::F_UP] = 1'b1;
        aflags[ax][ibt_pkg::F_HELD] = 1'b0;
        arel[ax] = ev_word[i][31:0];
      end
      adata[ax] = ev_word[i][63:32];
      touched[ax] = 1'b1;
    end
    ev_count = 0;
  endfunction

  function automatic axis_view_t predict_result(logic [1:0] op, logic [119:0] d);
    axis_view_t r;
    logic [31:0] ck, bk;
    int s, ax;
    r = '0;
    ck = {d[15:0], d[31:16]};
    bk = {d[15:0], d[47:32]};
    case (op)
      ibt_pkg::OP_MAP: r.status = apply_map(ck, bk, d[15:0]);
      ibt_pkg::OP_EVT: begin
        if (ev_count >= NEVT) r.status = ibt_pkg::ST_QFULL;
        else begin
          ev_key[ev_count] = {d[49], d[48], bk};
          ev_word[ev_count] = {d[113:82], d[81:50]};
          ev_count++;
        end
      end
      ibt_pkg::OP_TICK: apply_tick();
      default: begin
        s = find_slot(1'b1, ck);
        if (s < 0) r.status = ibt_pkg::ST_NOTFOUND;
        else begin
          ax = int'(clink[s]);
          r.down = aflags[ax][ibt_pkg::F_DOWN];
          r.held = aflags[ax][ibt_pkg::F_HELD];
          r.up = aflags[ax][ibt_pkg::F_UP];
          r.prs_stamp = aprs[ax];
          r.rel_stamp = arel[ax];
          r.payload = adata[ax];
          r.kind = akind[ax];
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    axis_view_t e;
    if (rst) begin
      fail_count = 0;
      n_axes = 0;
      ev_count = 0;
      expected_views.delete();
      for (int i = 0; i < NSLOT; i++) begin
        cused[i] = 1'b0;
        bused[i] = 1'b0;
      end
      for (int i = 0; i < NAXIS; i++) begin
        aflags[i] = '0; akind[i] = '0; aprs[i] = '0; arel[i] = '0; adata[i] = '0;
        touched[i] = 1'b0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_views.push_back(predict_result(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_views.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          e = expected_views.pop_front();
          compare_field("status", 32'(e.status), 32'(m_axis_tuser));
          compare_field("down_edge", 32'(e.down), 32'(m_axis_tdata[0]));
          compare_field("held", 32'(e.held), 32'(m_axis_tdata[1]));
          compare_field("up_edge", 32'(e.up), 32'(m_axis_tdata[2]));
          compare_field("pressed_stamp", e.prs_stamp, m_axis_tdata[34:3]);
          compare_field("released_stamp", e.rel_stamp, m_axis_tdata[66:35]);
          compare_field("axis_payload", e.payload, m_axis_tdata[98:67]);
          compare_field("axis_kind", 32'(e.kind), 32'(m_axis_tdata[114:99]));
        end
      end
    end
    pending_count = expected_views.size();
  end
endmodule

FILE: tb/testbench.sv
// Top of the input_binding_table_core testbench: clock, reset, stimulus, verdict.
// Depends on ibt_pkg, input_binding_table_core and ibt_checker.
`timescale 1ns / 1ps
module testbench;
  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;   // key_type, code_value, bind_value, press, release, stamp, payload
  logic [1:0]   s_axis_tuser;   // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;   // down, held, up, pressed_stamp, released_stamp, payload, kind
  logic [2:0]   m_axis_tuser;   // status
  int           fail_count;
  int           pending_count;
  int           cycle_count;
  bit           hold_off_req;
  bit           hold_off_done;

  input_binding_table_core dut (.*);

  ibt_checker checker_inst (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Small working sets so codes and bindings recur and the tables fill up.
  logic [15:0] type_pool [4];
  logic [15:0] code_pool [8];
  logic [15:0] bind_pool [8];

  task automatic send_beat(logic [1:0] op, logic [15:0] ty, logic [15:0] cv, logic [15:0] bv,
                           logic pr, logic rl, logic [31:0] st, logic [31:0] pl);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, pl, st, rl, pr, bv, cv, ty};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random(int n_items);
    int burst;
    logic [1:0] op;
    burst = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst == 0) begin
        send_gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1:    op = ibt_pkg::OP_MAP;
        2, 3, 4: op = ibt_pkg::OP_EVT;
        5:       op = ibt_pkg::OP_TICK;
        default: op = ibt_pkg::OP_GET;
      endcase
      if ($urandom_range(0, 19) == 0)
        send_beat(op, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom), $urandom, $urandom);
      else
        send_beat(op, type_pool[$urandom_range(0, 3)], code_pool[$urandom_range(0, 7)],
                  bind_pool[$urandom_range(0, 7)], 1'($urandom), 1'($urandom),
                  $urandom, $urandom);
    end
    s_axis_tvalid <= 0;
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    hold_off_req = 0;
    for (int i = 0; i < 4; i++) type_pool[i] = 16'($urandom);
    type_pool[0] = 16'h0000;
    type_pool[3] = 16'hFFFF;
    for (int i = 0; i < 8; i++) begin
      code_pool[i] = 16'($urandom);
      bind_pool[i] = 16'($urandom);
    end
    code_pool[0] = 16'h0000;
    code_pool[7] = 16'hFFFF;
    bind_pool[0] = 16'h0000;
    bind_pool[7] = 16'hFFFF;
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ibt_pkg::OP_MAP;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: unknown code, map, same axis, rebinding, press/release, press while held.
    send_beat(ibt_pkg::OP_GET, 16'h0000, 16'h0000, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_MAP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_MAP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_MAP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_MAP, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_EVT, 16'h0000, 16'h0, 16'h0000, 1'b1, 1'b0, 32'hFFFFFFFF,
              32'hFFFFFFFF);
    send_beat(ibt_pkg::OP_EVT, 16'h0000, 16'h0, 16'h1234, 1'b1, 1'b0, 32'd1, 32'd2);
    send_beat(ibt_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_GET, 16'h0000, 16'h0001, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_EVT, 16'h0000, 16'h0, 16'h0000, 1'b1, 1'b1, 32'd5, 32'd6);
    send_beat(ibt_pkg::OP_EVT, 16'h0000, 16'h0, 16'h0000, 1'b0, 1'b1, 32'hFFFFFFFF, 32'd7);
    send_beat(ibt_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_GET, 16'h0000, 16'h0001, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    send_beat(ibt_pkg::OP_GET, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    // Queue overflow, then drain.
    for (int i = 0; i < 17; i++)
      send_beat(ibt_pkg::OP_EVT, 16'($urandom), 16'h0, 16'($urandom), 1'b1, 1'b1,
                $urandom, $urandom);
    send_beat(ibt_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    drain_wait();

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req <= 1;
    send_random(40);
    drain_wait();

    send_random(500);
    drain_wait();

    // Fill axes and tables with fresh codes, with a few reads back.
    for (int i = 0; i < 40; i++) begin
      send_beat(ibt_pkg::OP_MAP, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b0,
                32'h0, 32'h0);
      if (i % 8 == 0)
        send_beat(ibt_pkg::OP_GET, type_pool[0], code_pool[0], 16'h0, 1'b0, 1'b0,
                  32'h0, 32'h0);
    end
    send_random(760);
    drain_wait();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Receiver stall pattern with occasional long hold-off on request.
  initial begin
    int phase;
    m_axis_tready <= 0;
    hold_off_done = 0;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 0;
        repeat (600) @(posedge clk);
        hold_off_done = 1;
      end
      phase++;
      if ((phase / 300) % 3 == 0) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) && (phase % 11 != 0);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 10000000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end
endmodule

FILE: input_binding_table_core.f
rtl/core/ibt_pkg.sv
rtl/core/ibt_ram.sv
rtl/core/input_binding_table_core.sv
tb/ibt_checker.sv
tb/testbench.sv
